// File: design/bmd_pkg.sv
// shared types, constants and register codes of the box mipmap downsampler
`default_nettype none

package bmd_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int MODE_W      = 2;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int NUM_LANES   = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HORIZ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VERT   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_COPY = 2'd0,
        OP_H2   = 2'd1,
        OP_V2   = 2'd2,
        OP_Q4   = 2'd3
    } lane_op_t;

    typedef logic [NUM_LANES-1:0][7:0] pixel_t;

    typedef struct packed {
        logic [7:0] channel_0;
        logic [7:0] channel_1;
        logic [7:0] channel_2;
        logic [7:0] channel_3;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_channel_0;
        logic [7:0] out_channel_1;
        logic [7:0] out_channel_2;
        logic [7:0] out_channel_3;
        logic       row_end;
        logic       frame_end;
    } out_word_t;

endpackage

`default_nettype wire

// File: design/bmd_lane.sv
// one byte lane of the box filter: copy, pair average or quad average
`default_nettype none

module bmd_lane
    import bmd_pkg::*;
(
    input  wire lane_op_t   op,
    input  wire logic [7:0] cur,
    input  wire logic [7:0] left,
    input  wire logic [7:0] above,
    input  wire logic [7:0] above_left,
    output logic [7:0]      result
);

    logic [8:0] sum_h;
    logic [8:0] sum_v;
    logic [9:0] sum_q;

    always_comb
    begin
        sum_h = {1'b0, left} + {1'b0, cur};
        sum_v = {1'b0, above} + {1'b0, cur};
        sum_q = {1'b0, sum_h} + {2'b00, above} + {2'b00, above_left};
        case (op)
            OP_COPY: result = cur;
            OP_H2:   result = sum_h[8:1];
            OP_V2:   result = sum_v[8:1];
            OP_Q4:   result = sum_q[9:2];
            default: result = cur;
        endcase
    end

endmodule

`default_nettype wire

// File: design/bmd_line_store.sv
// line store holding the even row, one write and one registered read per cycle
`default_nettype none

module bmd_line_store
    import bmd_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          write_en,
    input  wire logic [AW-1:0] write_addr,
    input  wire pixel_t        write_data,
    input  wire logic          read_en,
    input  wire logic [AW-1:0] read_addr,
    output pixel_t             read_data
);

    pixel_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[write_addr] <= write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_en)
        begin
            read_data <= mem[read_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/box_mipmap_downsampler.sv
// top level of the box mipmap downsampler: counters, line store, lanes, output merge
//
// channel   dir  handshake            word
// in        in   in_valid/in_ready    in_word_t, one rgba pixel in raster order
// out       out  out_valid/out_ready  out_word_t, averaged pixel with row and frame ends
// cfg       in   cfg_write_en         cfg_index selects mode, width or height
//
// one pixel accepted per cycle unless the lane stage stalls
// the registered line store read feeds the lane stage, which loads the output register
// reset clears counters, left pixel and valids, presets config; line store not cleared
// a stalled output holds its word while one more pixel waits in the lane stage
`default_nettype none

module box_mipmap_downsampler
    import bmd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_word_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_word_t                   out_data,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (CW >= WIDTH_W) ? CW + 1 : WIDTH_W + 1;

    logic [MODE_W-1:0]   mode_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;

    logic [CW-1:0]       col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    pixel_t              left_pixel_reg;

    logic                s1_valid_reg;
    logic                s1_emit_reg;
    lane_op_t            s1_op_reg;
    pixel_t              s1_cur_reg;
    pixel_t              s1_left_reg;
    logic                s1_row_end_reg;
    logic                s1_frame_end_reg;
    pixel_t              above_left_reg;
    pixel_t              above_data;

    logic                out_valid_reg;
    out_word_t           out_reg;
    out_word_t           out_next;

    logic                accept;
    logic                s1_adv;
    logic                out_load;

    logic [MODE_W-1:0]   mode_eff;
    logic [LW-1:0]       width_ext;
    logic [CW-1:0]       col_last;
    logic [HEIGHT_W-1:0] row_last;
    logic                last_col;
    logic                last_row;
    logic                odd_col;
    logic                odd_row;
    logic                horiz;
    logic                emit;
    lane_op_t            op;
    logic                store_write;
    logic                left_load;
    pixel_t              cur_pixel;
    pixel_t              result;

    assign cur_pixel = {in_data.channel_3, in_data.channel_2,
                        in_data.channel_1, in_data.channel_0};

    // handshake
    assign out_load  = s1_valid_reg && s1_emit_reg && (!out_valid_reg || out_ready);
    assign s1_adv    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // frame geometry and per pixel decision
    always_comb
    begin
        mode_eff  = (mode_reg == MODE_UNUSED) ? MODE_BOTH : mode_reg;
        width_ext = LW'(image_width_reg);
        if (width_ext == '0)
        begin
            col_last = '0;
        end
        else if (width_ext > LW'(MAX_WIDTH))
        begin
            col_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = CW'(width_ext - LW'(1));
        end
        row_last = (image_height_reg == '0) ? '0 : image_height_reg - HEIGHT_W'(1);
        last_col = col_reg >= col_last;
        last_row = row_reg >= row_last;
        odd_col  = col_reg[0];
        odd_row  = row_reg[0];
        horiz    = (mode_eff == MODE_HORIZ) ||
                   ((mode_eff == MODE_BOTH) && !odd_row && last_row);

        emit        = 1'b0;
        op          = OP_COPY;
        store_write = 1'b0;
        left_load   = 1'b0;
        if (horiz)
        begin
            if (odd_col)
            begin
                emit = 1'b1;
                op   = OP_H2;
            end
            else if (last_col)
            begin
                emit = 1'b1;
            end
            else
            begin
                left_load = 1'b1;
            end
        end
        else if (mode_eff == MODE_BOTH)
        begin
            if (!odd_row)
            begin
                store_write = 1'b1;
            end
            else if (odd_col)
            begin
                emit = 1'b1;
                op   = OP_Q4;
            end
            else if (last_col)
            begin
                emit = 1'b1;
                op   = OP_V2;
            end
            else
            begin
                left_load = 1'b1;
            end
        end
        else
        begin
            if (odd_row)
            begin
                emit = 1'b1;
                op   = OP_V2;
            end
            else if (last_row)
            begin
                emit = 1'b1;
            end
            else
            begin
                store_write = 1'b1;
            end
        end
    end

    // config, counters and valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_BOTH;
            image_width_reg  <= WIDTH_W'(256);
            image_height_reg <= HEIGHT_W'(256);
            col_reg          <= '0;
            row_reg          <= '0;
            left_pixel_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg         <= cfg_data[MODE_W-1:0];
                    REG_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                    default:    ;
                endcase
            end
            if (accept)
            begin
                if (left_load)
                begin
                    left_pixel_reg <= cur_pixel;
                end
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // lane stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg      <= emit;
            s1_op_reg        <= op;
            s1_cur_reg       <= cur_pixel;
            s1_left_reg      <= left_pixel_reg;
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
        end
        // the previous column's line store word, for the quad average
        if (s1_adv)
        begin
            above_left_reg <= above_data;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    bmd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk        (clk),
        .write_en   (accept && store_write),
        .write_addr (col_reg),
        .write_data (cur_pixel),
        .read_en    (accept),
        .read_addr  (col_reg),
        .read_data  (above_data)
    );

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        bmd_lane u_lane (
            .op         (s1_op_reg),
            .cur        (s1_cur_reg[k]),
            .left       (s1_left_reg[k]),
            .above      (above_data[k]),
            .above_left (above_left_reg[k]),
            .result     (result[k])
        );
    end

    // merge lanes into the output word
    always_comb
    begin
        out_next.out_channel_0 = result[0];
        out_next.out_channel_1 = result[1];
        out_next.out_channel_2 = result[2];
        out_next.out_channel_3 = result[3];
        out_next.row_end       = s1_row_end_reg;
        out_next.frame_end     = s1_frame_end_reg;
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_box_mipmap_downsampler.sv
// self-checking testbench for the box mipmap downsampler, predicting each output word
`timescale 1ns / 1ps

module tb_box_mipmap_downsampler;
    import bmd_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;
    logic cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [MODE_W-1:0] cfg_mode = MODE_BOTH;
    logic [WIDTH_W-1:0] cfg_width = 12'd256;
    logic [HEIGHT_W-1:0] cfg_height = 16'd256;
    pixel_t even_row [MAX_WIDTH_DEF];
    pixel_t left_pixel = '0;
    int column_count = 0;
    int row_count = 0;

    out_word_t pending_pixels [$];
    int mismatch_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int idle_cycles = 0;

    box_mipmap_downsampler DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return cfg_width;
    endfunction

    function automatic int eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic pixel_t avg2(pixel_t a, pixel_t b);
        pixel_t r;
        for (int k = 0; k < NUM_LANES; k++)
            r[k] = 8'((int'(a[k]) + int'(b[k])) >> 1);
        return r;
    endfunction

    function automatic pixel_t avg4(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
        pixel_t r;
        for (int k = 0; k < NUM_LANES; k++)
            r[k] = 8'((int'(a[k]) + int'(b[k]) + int'(c[k]) + int'(d[k])) >> 2);
        return r;
    endfunction

    function automatic pixel_t stored(int idx);
        return (idx < MAX_WIDTH_DEF) ? even_row[idx] : '0;
    endfunction

    function automatic in_word_t solid(logic [7:0] value);
        return '{value, value, value, value};
    endfunction

    function automatic in_word_t rand_pixel();
        logic [3:0][7:0] bytes;
        int pick;
        for (int k = 0; k < 4; k++)
        begin
            pick = $urandom_range(9);
            bytes[k] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        end
        return in_word_t'(bytes);
    endfunction

    task automatic downsample_pixel(input in_word_t px);
        pixel_t cur;
        pixel_t res;
        int w;
        int h;
        int c;
        int r;
        logic [MODE_W-1:0] m;
        bit last_col;
        bit last_row;
        bit odd_col;
        bit odd_row;
        bit emit;
        out_word_t word;
        cur[0] = px.channel_0;
        cur[1] = px.channel_1;
        cur[2] = px.channel_2;
        cur[3] = px.channel_3;
        res = '0;
        emit = 1'b0;
        w = eff_width();
        h = eff_height();
        c = column_count;
        r = row_count;
        m = (cfg_mode == MODE_UNUSED) ? MODE_BOTH : cfg_mode;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        odd_col = c[0];
        odd_row = r[0];
        if (m == MODE_HORIZ || (m == MODE_BOTH && !odd_row && last_row))
        begin
            if (odd_col)
            begin
                res = avg2(left_pixel, cur);
                emit = 1'b1;
            end
            else if (last_col)
            begin
                res = cur;
                emit = 1'b1;
            end
            else
                left_pixel = cur;
        end
        else if (m == MODE_BOTH)
        begin
            if (!odd_row)
            begin
                if (c < MAX_WIDTH_DEF)
                    even_row[c] = cur;
            end
            else if (odd_col)
            begin
                res = avg4(stored(c - 1), stored(c), left_pixel, cur);
                emit = 1'b1;
            end
            else if (last_col)
            begin
                res = avg2(stored(c), cur);
                emit = 1'b1;
            end
            else
                left_pixel = cur;
        end
        else
        begin
            if (odd_row)
            begin
                res = avg2(stored(c), cur);
                emit = 1'b1;
            end
            else if (last_row)
            begin
                res = cur;
                emit = 1'b1;
            end
            else if (c < MAX_WIDTH_DEF)
                even_row[c] = cur;
        end
        if (last_col)
        begin
            column_count = 0;
            row_count = last_row ? 0 : ((r + 1) & 16'hFFFF);
        end
        else
            column_count = c + 1;
        if (emit)
        begin
            word.out_channel_0 = res[0];
            word.out_channel_1 = res[1];
            word.out_channel_2 = res[2];
            word.out_channel_3 = res[3];
            word.row_end = last_col;
            word.frame_end = last_col && last_row;
            pending_pixels.push_back(word);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // registers change only with the block idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_MODE:   cfg_mode = value[MODE_W-1:0];
            REG_WIDTH:  cfg_width = value[WIDTH_W-1:0];
            REG_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup_frame(input logic [15:0] mode_val, input logic [15:0] width_val,
                               input logic [15:0] height_val);
        write_reg(REG_MODE, mode_val);
        write_reg(REG_WIDTH, width_val);
        write_reg(REG_HEIGHT, height_val);
    endtask

    task automatic send_pixel(input in_word_t px);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        downsample_pixel(px);
    endtask

    task automatic send_frame(output int count);
        count = eff_width() * eff_height();
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel());
    endtask

    task automatic test_lane_extremes();
        setup_frame(16'(MODE_BOTH), 16'd2, 16'd2);
        repeat (4) send_pixel(solid(8'hFF));
        setup_frame(16'(MODE_HORIZ), 16'd2, 16'd1);
        send_pixel(solid(8'hFF));
        send_pixel(solid(8'h00));
        setup_frame(16'(MODE_VERT), 16'd1, 16'd2);
        send_pixel(solid(8'h01));
        send_pixel(solid(8'h00));
    endtask

    task automatic test_odd_edges();
        int n;
        setup_frame(16'(MODE_BOTH), 16'd3, 16'd3);
        send_frame(n);
        setup_frame(16'(MODE_HORIZ), 16'd3, 16'd1);
        send_frame(n);
        setup_frame(16'(MODE_VERT), 16'd2, 16'd3);
        send_frame(n);
    endtask

    task automatic test_unused_mode_and_zero_size();
        int n;
        write_reg(REG_MODE, 16'hFFFF);
        write_reg(REG_WIDTH, 16'd2);
        write_reg(REG_HEIGHT, 16'd2);
        send_frame(n);
        setup_frame(16'(MODE_VERT), 16'd0, 16'd0);
        send_frame(n);
    endtask

    // width and height shrink while a frame is open
    task automatic test_midframe_reconfig();
        setup_frame(16'(MODE_HORIZ), 16'd6, 16'd4);
        repeat (3) send_pixel(rand_pixel());
        write_reg(REG_WIDTH, 16'd2);
        send_pixel(rand_pixel());
        write_reg(REG_HEIGHT, 16'd1);
        repeat (2) send_pixel(rand_pixel());
    endtask

    task automatic test_random_frames(input int target);
        int sent;
        int n;
        logic [15:0] w;
        sent = 0;
        while (sent < target)
        begin
            w = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 9))
                                          : 16'($urandom_range(10, 40));
            setup_frame(16'($urandom_range(3)), w, 16'($urandom_range(0, 7)));
            send_frame(n);
            sent += n;
        end
    endtask

    // an over-wide line is cut short by lowering the width
    task automatic test_widest_line();
        setup_frame(16'(MODE_BOTH), 16'h0FFF, 16'd2);
        repeat (3) send_pixel(rand_pixel());
        write_reg(REG_WIDTH, 16'd4);
        repeat (5) send_pixel(rand_pixel());
    endtask

    // tallest frame is cut short by lowering the height
    task automatic test_tallest_frame();
        setup_frame(16'(MODE_VERT), 16'd1, 16'hFFFF);
        repeat (4) send_pixel(rand_pixel());
        write_reg(REG_HEIGHT, 16'd5);
        send_pixel(rand_pixel());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("output word with none expected");
            else
            begin
                automatic out_word_t want = pending_pixels.pop_front();
                check_field("out_channel_0", out_data.out_channel_0, want.out_channel_0);
                check_field("out_channel_1", out_data.out_channel_1, want.out_channel_1);
                check_field("out_channel_2", out_data.out_channel_2, want.out_channel_2);
                check_field("out_channel_3", out_data.out_channel_3, want.out_channel_3);
                check_field("row_end", out_data.row_end, want.row_end);
                check_field("frame_end", out_data.frame_end, want.frame_end);
            end
        end
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 20;
        sink_idle_pct = 84;
        test_lane_extremes();
        test_odd_edges();
        test_unused_mode_and_zero_size();
        test_midframe_reconfig();
        test_random_frames(150);

        src_idle_pct = 84;
        sink_idle_pct = 20;
        test_random_frames(150);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_frames(150);
        test_widest_line();
        test_tallest_frame();

        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
